// ===== sv/wfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared widths and operation codes of the wait-for graph guard.
// ----------------------------------------------------------------------------
package wfg_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int MASK_W    = 16;

  localparam logic [OP_W-1:0] OP_QUERY   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_EDGES   = 3'd3;
  localparam logic [OP_W-1:0] OP_RM_EDGE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLR_OUT = 3'd5;

  // memory port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage

// ===== sv/wait_for_graph_deadlock_guard_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_guard_top
// Wait-for graph over transaction slots with cycle check on edge insertion.
// ----------------------------------------------------------------------------
// channel  ports                                  dir
// in       in_valid/in_ready, operation, txn,     in
//          other, dest_mask
// out      out_valid/out_ready, out_answer         out
//
// Rows live in one memory with a registered read port. Query and add node
// need no row access; edge remove and clear outgoing read row t and then
// write it; remove node sweeps all rows, clearing column t and row t.
// Add edges: SLOTS closure rounds, each reading all rows, then decide and
// commit by reading row t again and writing it with the new edges.
// After reset a clearing pass writes zero to all SLOTS rows.
// The result sits in an output register; a stalled result blocks new requests,
// and the next request is taken the cycle after the result is taken.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_guard_top #(
  parameter int SLOTS = wfg_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wfg_pkg::OP_W-1:0]   in_operation,
  input  logic [wfg_pkg::IDX_W-1:0]  in_txn,
  input  logic [wfg_pkg::IDX_W-1:0]  in_other,
  input  logic [wfg_pkg::MASK_W-1:0] in_dest_mask,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_answer
);
  import wfg_pkg::*;

  localparam int CW = $clog2(SLOTS);
  localparam int RW = $clog2(SLOTS + 1);
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2,
                         S_WR = 3'd3, S_SWEEP = 3'd4, S_REACH = 3'd5,
                         S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [IDX_W-1:0]  t_r, t_nxt, o_r, o_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [SLOTS-1:0]  pres_r, pres_nxt, reach_r, reach_nxt, racc_r, racc_nxt;
  logic [CW:0]       cnt_r, cnt_nxt;  // sweep address, one extra bit for end
  logic [RW-1:0]     round_r, round_nxt;
  logic              pend_r, pend_nxt; // read in flight: row cnt_r-1 or t
  logic              out_valid_r, out_valid_nxt, ans_r, ans_nxt;
  mem_req_t          req;
  logic [SLOTS-1:0]  wdata, rdata, mask_s, tbit;
  logic [CW-1:0]     prow;
  logic              t_ok, o_ok;

  wfg_mem #(.SLOTS(SLOTS)) u_mem (.clk(clk), .req(req), .wdata(wdata), .rdata(rdata));

  // mask bits at or above SLOTS name absent slots
  always_comb begin
    mask_s = '0;
    for (int i = 0; i < SLOTS && i < MASK_W; i++) mask_s[i] = mask_r[i];
  end
  assign t_ok = (32'(t_r) < SLOTS) && pres_r[t_r[CW-1:0]];
  assign o_ok = (32'(o_r) < SLOTS) && pres_r[o_r[CW-1:0]];
  assign tbit = SLOTS'(1) << t_r[CW-1:0];
  assign prow = CW'(cnt_r - 1'b1);
  assign in_ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_answer = ans_r;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; t_nxt = t_r; o_nxt = o_r;
    mask_nxt = mask_r; pres_nxt = pres_r; reach_nxt = reach_r;
    racc_nxt = racc_r; cnt_nxt = cnt_r; round_nxt = round_r;
    pend_nxt = 1'b0; out_valid_nxt = out_valid_r; ans_nxt = ans_r;
    req = '0; req.raddr = t_r; req.waddr = t_r; wdata = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        req.we = 1'b1; req.waddr = IDX_W'(cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == SLOTS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_operation; t_nxt = in_txn; o_nxt = in_other;
          mask_nxt = in_dest_mask; cnt_nxt = '0; state_nxt = S_DONE;
          ans_nxt = 1'b0;
          req.raddr = in_txn;
          case (in_operation)
            OP_REMOVE, OP_EDGES, OP_RM_EDGE, OP_CLR_OUT: state_nxt = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: begin
        // row t is now on rdata
        state_nxt = S_DONE;
        case (op_r)
          OP_QUERY: ;
          OP_REMOVE: if (t_ok) begin cnt_nxt = '0; state_nxt = S_SWEEP; end
          OP_EDGES: if (t_ok) begin
            racc_nxt = tbit; reach_nxt = tbit; round_nxt = '0; cnt_nxt = '0;
            state_nxt = S_REACH;
          end
          OP_RM_EDGE: if (t_ok && o_ok) begin
            req.we = 1'b1; wdata = rdata & ~(SLOTS'(1) << o_r[CW-1:0]);
          end
          OP_CLR_OUT: if (t_ok) req.we = 1'b1;
          default: ;
        endcase
      end
      S_SWEEP: begin
        // read row cnt, write back previous row with column t cleared
        req.raddr = IDX_W'(cnt_r);
        if (pend_r) begin
          req.we = 1'b1; req.waddr = IDX_W'(prow);
          wdata = (prow == t_r[CW-1:0]) ? '0 : (rdata & ~tbit);
        end
        if (32'(cnt_r) == SLOTS) begin
          pres_nxt = pres_r & ~tbit; state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1; pend_nxt = 1'b1;
        end
      end
      S_REACH: begin
        req.raddr = IDX_W'(cnt_r);
        if (pend_r && pres_r[prow] && |(rdata & reach_r)) racc_nxt[prow] = 1'b1;
        if (32'(cnt_r) == SLOTS) begin
          reach_nxt = racc_nxt; cnt_nxt = '0;
          round_nxt = round_r + 1'b1;
          if (32'(round_r) == SLOTS - 1) state_nxt = S_WR;
        end else begin
          cnt_nxt = cnt_r + 1'b1; pend_nxt = 1'b1;
        end
      end
      S_WR: begin
        // fetch row t again, commit next cycle
        req.raddr = t_r; state_nxt = S_DONE; pend_nxt = 1'b1;
        if ((mask_r & ~MASK_W'(mask_s & pres_r)) != '0 ||
            (mask_s & reach_r) != '0) begin
          pend_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (op_r == OP_EDGES && pend_r) begin
          req.we = 1'b1; wdata = rdata | mask_s; ans_nxt = 1'b1;
        end
        if (op_r == OP_QUERY) ans_nxt = t_ok;
        if (op_r == OP_ADD && 32'(t_r) < SLOTS) pres_nxt = pres_r | tbit;
        out_valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0; pres_r <= '0; reach_r <= '0;
      out_valid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; pres_r <= pres_nxt;
      reach_r <= reach_nxt; out_valid_r <= out_valid_nxt; pend_r <= pend_nxt;
    end
    op_r <= op_nxt; t_r <= t_nxt; o_r <= o_nxt; mask_r <= mask_nxt;
    racc_r <= racc_nxt; round_r <= round_nxt; ans_r <= ans_nxt;
  end
endmodule

// ===== sv/wfg_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_mem
// Adjacency matrix: one row per slot, one write and one registered read port.
// ----------------------------------------------------------------------------
module wfg_mem #(
  parameter int SLOTS = wfg_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  wfg_pkg::mem_req_t  req,
  input  logic [SLOTS-1:0]   wdata,
  output logic [SLOTS-1:0]   rdata
);
  import wfg_pkg::*;
  logic [SLOTS-1:0] rows [SLOTS];
  logic [SLOTS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      rows[req.waddr[$clog2(SLOTS)-1:0]] <= wdata;
    end
    rdata_r <= rows[req.raddr[$clog2(SLOTS)-1:0]];
  end
  assign rdata = rdata_r;
endmodule

// ===== dv/wait_for_graph_deadlock_guard_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_guard_top_tb
// Self-checking bench for the wait-for graph guard: directed corner requests,
// then random graph building with cycle attempts, random idling on both
// sides and one long result stall. Answers are checked against a local model.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_guard_top_tb;
  import wfg_pkg::*;

  localparam int NSLOT      = 16;
  localparam int CYC_LIMIT  = 3000000;

  // codes with no operation behind them
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [IDX_W-1:0]  in_txn;
  logic [IDX_W-1:0]  in_other;
  logic [MASK_W-1:0] in_dest_mask;
  logic              out_valid;
  logic              out_ready;
  logic              out_answer;

  // graph model
  logic [NSLOT-1:0] node_present;
  logic [NSLOT-1:0] waits_on [NSLOT];
  logic [NSLOT-1:0] reach_to_src;

  logic answer_q[$];
  int   errors;
  int   sent;
  int   checked;
  int   accepted_edges;
  int   refused_edges;
  int   cycles;
  bit   hold_results;

  wait_for_graph_deadlock_guard_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_txn(in_txn),
    .in_other(in_other), .in_dest_mask(in_dest_mask),
    .out_valid(out_valid), .out_ready(out_ready), .out_answer(out_answer)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [NSLOT-1:0] nodes_reaching(input logic [3:0] src);
    logic [NSLOT-1:0] r;
    logic [NSLOT-1:0] nxt;
    r = '0;
    r[src] = 1'b1;
    for (int rnd = 0; rnd < NSLOT; rnd++) begin
      nxt = r;
      for (int i = 0; i < NSLOT; i++)
        if (node_present[i] && |(waits_on[i] & r)) nxt[i] = 1'b1;
      r = nxt;
    end
    return r;
  endfunction

  function automatic logic predict_answer(input logic [OP_W-1:0] op, input logic [3:0] t,
                                          input logic [3:0] o, input logic [15:0] mask);
    logic ans;
    ans = 1'b0;
    case (op)
      OP_QUERY: ans = node_present[t];
      OP_ADD: node_present[t] = 1'b1;
      OP_REMOVE: begin
        if (node_present[t]) begin
          waits_on[t] = '0;
          for (int i = 0; i < NSLOT; i++) waits_on[i][t] = 1'b0;
          node_present[t] = 1'b0;
        end
      end
      OP_EDGES: begin
        if (node_present[t]) begin
          reach_to_src = nodes_reaching(t);
          if ((mask & ~node_present) == '0 && (mask & reach_to_src) == '0) begin
            waits_on[t] |= mask;
            ans = 1'b1;
          end
        end
      end
      OP_RM_EDGE: if (node_present[t] && node_present[o]) waits_on[t][o] = 1'b0;
      OP_CLR_OUT: if (node_present[t]) waits_on[t] = '0;
      default: ;
    endcase
    return ans;
  endfunction

  // valid stays up after acceptance; the next request either replaces the
  // payload at once or drops valid for its idle gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic [3:0] t,
                              input logic [3:0] o, input logic [15:0] mask);
    int   gap;
    logic ans;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_txn       <= t;
    in_other     <= o;
    in_dest_mask <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ans = predict_answer(op, t, o, mask);
    answer_q = {answer_q, ans};
    if (op == OP_EDGES) begin
      if (ans) accepted_edges++;
      else refused_edges++;
    end
    sent++;
  endtask

  // result side: random stalls, plus a forced hold-off when requested
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0 || hold_results) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result answer=%0b", $time, out_answer);
        errors++;
      end else begin
        if (out_answer !== answer_q[0]) begin
          $display("%0t: answer mismatch expected=%0b actual=%0b",
                   $time, answer_q[0], out_answer);
          errors++;
        end
        void'(answer_q.pop_front());
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout with %0d results outstanding", answer_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_corners();
    send_request(OP_QUERY, 4'd0, 4'd0, 16'h0000);
    send_request(OP_EDGES, 4'd3, 4'd0, 16'h0000);
    send_request(OP_REMOVE, 4'd3, 4'd0, 16'h0000);
    send_request(OP_RM_EDGE, 4'd3, 4'd4, 16'h0000);
    send_request(OP_CLR_OUT, 4'd3, 4'd0, 16'h0000);
    for (int i = 0; i < NSLOT; i++) send_request(OP_ADD, i[3:0], 4'd0, 16'h0000);
    send_request(OP_ADD, 4'd15, 4'd0, 16'h0000);
    send_request(OP_QUERY, 4'd15, 4'd0, 16'hFFFF);
    send_request(OP_EDGES, 4'd0, 4'd0, 16'h0000);
    send_request(OP_EDGES, 4'd0, 4'd0, 16'h0001);
    send_request(OP_EDGES, 4'd0, 4'd0, 16'h0006);
    send_request(OP_EDGES, 4'd0, 4'd0, 16'h0002);
    send_request(OP_EDGES, 4'd1, 4'd0, 16'h8000);
    send_request(OP_EDGES, 4'd15, 4'd0, 16'h0001);
    send_request(OP_RM_EDGE, 4'd1, 4'd15, 16'h0000);
    send_request(OP_EDGES, 4'd15, 4'd0, 16'h0001);
    send_request(OP_SPARE_A, 4'd15, 4'd15, 16'hFFFF);
    send_request(OP_SPARE_B, 4'd0, 4'd0, 16'h0000);
    send_request(OP_REMOVE, 4'd0, 4'd0, 16'h0000);
    send_request(OP_EDGES, 4'd2, 4'd0, 16'h0001);
    send_request(OP_CLR_OUT, 4'd15, 4'd0, 16'h0000);
  endtask

  // mostly well-formed graph traffic with random content and some noise
  task automatic test_random(input int count);
    logic [OP_W-1:0] op;
    logic [3:0]      t;
    logic [15:0]     mask;
    int              pick;
    for (int n = 0; n < count; n++) begin
      t    = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 12) op = OP_ADD;
      else if (pick < 18) op = OP_REMOVE;
      else if (pick < 60) op = OP_EDGES;
      else if (pick < 70) op = OP_RM_EDGE;
      else if (pick < 75) op = OP_CLR_OUT;
      else if (pick < 95) op = OP_QUERY;
      else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_B : OP_SPARE_A;
      case ($urandom_range(0, 4))
        0: mask = 16'($urandom_range(0, 16'hFFFF));
        1: mask = '0;
        default: mask = (16'h1 << $urandom_range(0, 15)) |
                        (($urandom_range(0, 1) != 0) ? (16'h1 << $urandom_range(0, 15)) : 16'h0);
      endcase
      // mostly aim at present nodes so that closure gets deep
      if (op == OP_EDGES && $urandom_range(0, 3) != 0) mask &= node_present;
      send_request(op, t, 4'($urandom_range(0, 15)), mask);
    end
  endtask

  task automatic test_backpressure();
    hold_results = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    int settle;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_QUERY;
    in_txn       = '0;
    in_other     = '0;
    in_dest_mask = '0;
    hold_results = 1'b0;
    errors = 0; sent = 0; checked = 0; cycles = 0;
    accepted_edges = 0; refused_edges = 0;
    node_present = '0;
    reach_to_src = '0;
    for (int i = 0; i < NSLOT; i++) waits_on[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_backpressure();
    test_random(1700);
    in_valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 600) begin
      @(posedge clk);
      settle++;
    end
    $display("Sent %0d requests, checked %0d answers", sent, checked);
    $display("Edge insertions: %0d accepted, %0d refused as cycles or absent",
             accepted_edges, refused_edges);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
